// ----- rtl/gvt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the grid validity triangulator: field widths, default parameter
// values and the quad classification codes. It depends on nothing else.
package gvt_pkg;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_INDEX_WIDTH = 32;
    localparam int VDIV_W          = 10;
    localparam int ROW_W           = 22;
    localparam int CORNER_W        = 32;
    localparam int KIND_W          = 3;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [KIND_W-1:0] {
        QK_FULL,
        QK_NO_A,
        QK_NO_B,
        QK_NO_C,
        QK_NO_D
    } t_quad_kind;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } t_back_state;

endpackage

// ----- rtl/gvt_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual port RAM with one write port and one registered read port.
// A read and a write at the same address return the old data. No dependencies.
module gvt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/gvt_fifo.sv -----
`timescale 1ns / 1ps
// Small first-in first-out queue of classified quads between front and back.
// It depends on nothing else; DEPTH must be a power of two.
module gvt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/gvt_front.sv -----
`timescale 1ns / 1ps
// Front part: takes vertex beats, tracks row and column, keeps the line buffer
// and classifies each quad. Depends on gvt_pkg and gvt_ram.
module gvt_front #(
    parameter int MAX_COLUMNS = gvt_pkg::DEF_MAX_COLUMNS,
    parameter int INDEX_WIDTH = gvt_pkg::DEF_INDEX_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [gvt_pkg::VDIV_W-1:0] i_cfg_wr_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_vertex_valid,
    input  logic                      i_row_bridge,
    input  logic                      i_mesh_start,
    output logic                      o_push,
    output logic [gvt_pkg::KIND_W+4*INDEX_WIDTH-1:0] o_push_data,
    input  logic                      i_queue_full
);

    localparam int VW       = gvt_pkg::VDIV_W;
    localparam int IW       = INDEX_WIDTH;
    localparam int LB_DEPTH = (MAX_COLUMNS < (1 << VW)) ? MAX_COLUMNS : (1 << VW);
    localparam int AW       = $clog2(LB_DEPTH);
    localparam logic [VW-1:0] VDIV_CAP = VW'(LB_DEPTH - 1);

    logic [VW-1:0]              r_vdiv;
    logic [VW-1:0]              r_col;
    logic [gvt_pkg::ROW_W-1:0]  r_row;
    logic [IW-1:0]              r_base;
    logic                       r_left;
    logic                       r_bridged;
    logic                       r_ul;
    logic                       r_s1_valid;
    logic                       r_s1_en;
    logic                       r_s1_b;
    logic                       r_s1_d;
    logic [IW-1:0]              r_s1_id;
    logic [VW:0]                r_s1_stride;

    logic [VW-1:0]              eff_vdiv;
    logic [VW:0]                stride;
    logic [VW-1:0]              col_cur;
    logic [gvt_pkg::ROW_W-1:0]  row_cur;
    logic [IW-1:0]              base_cur;
    logic [VW-1:0]              col_j;
    logic                       quad_en;
    logic                       accept;
    logic                       above;
    logic                       hit;
    logic                       s1_done;
    gvt_pkg::t_quad_kind        kind;
    logic [IW-1:0]              idx_a;
    logic [IW-1:0]              idx_b;
    logic [IW-1:0]              idx_c;

    assign eff_vdiv = (r_vdiv > VDIV_CAP) ? VDIV_CAP : r_vdiv;
    assign stride   = {1'b0, eff_vdiv} + (VW + 1)'(1);
    assign col_cur  = i_mesh_start ? '0 : r_col;
    assign row_cur  = i_mesh_start ? '0 : r_row;
    assign base_cur = i_mesh_start ? '0 : r_base;
    assign col_j    = (col_cur > VDIV_CAP) ? VDIV_CAP : col_cur;
    assign quad_en  = (row_cur != '0) && (col_j != '0) && r_bridged;

    assign accept  = i_valid && o_ready;
    assign s1_done = !(r_s1_en && hit) || !i_queue_full;
    assign o_ready = !r_s1_valid || s1_done;

    gvt_ram #(
        .WIDTH (1),
        .DEPTH (LB_DEPTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (col_j[AW-1:0]),
        .i_wr_data (i_vertex_valid),
        .i_rd_en   (accept),
        .i_rd_addr (col_j[AW-1:0]),
        .o_rd_data (above)
    );

    always_comb begin
        hit  = 1'b1;
        kind = gvt_pkg::QK_FULL;
        priority if (r_ul && r_s1_b && above && r_s1_d) begin
            kind = gvt_pkg::QK_FULL;
        end else if (r_ul && r_s1_b && above) begin
            kind = gvt_pkg::QK_NO_D;
        end else if (r_s1_b && above && r_s1_d) begin
            kind = gvt_pkg::QK_NO_A;
        end else if (r_ul && above && r_s1_d) begin
            kind = gvt_pkg::QK_NO_B;
        end else if (r_ul && r_s1_b && r_s1_d) begin
            kind = gvt_pkg::QK_NO_C;
        end else begin
            hit = 1'b0;
        end
    end

    assign idx_c = r_s1_id - IW'(r_s1_stride);
    assign idx_a = r_s1_id - IW'(r_s1_stride) - IW'(1);
    assign idx_b = r_s1_id - IW'(1);

    assign o_push      = r_s1_valid && r_s1_en && hit && !i_queue_full;
    assign o_push_data = {kind, idx_a, idx_b, idx_c, r_s1_id};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vdiv     <= VW'(1);
            r_col      <= '0;
            r_row      <= '0;
            r_base     <= '0;
            r_left     <= 1'b0;
            r_bridged  <= 1'b0;
            r_ul       <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vdiv <= i_cfg_wr_data;
            end
            if (r_s1_valid && s1_done) begin
                r_ul <= above;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (accept) begin
                r_left <= i_vertex_valid;
                if (col_cur >= eff_vdiv) begin
                    r_col     <= '0;
                    r_row     <= row_cur + gvt_pkg::ROW_W'(1);
                    r_base    <= base_cur + IW'(stride);
                    r_bridged <= i_row_bridge;
                end else begin
                    r_col  <= col_cur + VW'(1);
                    r_row  <= row_cur;
                    r_base <= base_cur;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_en     <= quad_en;
            r_s1_b      <= r_left;
            r_s1_d      <= i_vertex_valid;
            r_s1_id     <= base_cur + IW'(col_j);
            r_s1_stride <= stride;
        end
    end

endmodule

// ----- rtl/gvt_back.sv -----
`timescale 1ns / 1ps
// Back part: turns classified quads from the queue into triangle beats held in
// an output register. Depends on gvt_pkg.
module gvt_back #(
    parameter int INDEX_WIDTH = gvt_pkg::DEF_INDEX_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [gvt_pkg::KIND_W+4*INDEX_WIDTH-1:0] i_job,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gvt_pkg::CORNER_W-1:0] o_corner_a,
    output logic [gvt_pkg::CORNER_W-1:0] o_corner_b,
    output logic [gvt_pkg::CORNER_W-1:0] o_corner_c,
    output logic                        o_last
);

    localparam int IW = INDEX_WIDTH;
    localparam int CW = gvt_pkg::CORNER_W;

    gvt_pkg::t_back_state r_state;
    gvt_pkg::t_back_state n_state;
    logic                 r_valid;
    logic [CW-1:0]        r_a;
    logic [CW-1:0]        r_b;
    logic [CW-1:0]        r_c;
    logic                 r_last;

    gvt_pkg::t_quad_kind  kind;
    logic [IW-1:0]        idx_a;
    logic [IW-1:0]        idx_b;
    logic [IW-1:0]        idx_c;
    logic [IW-1:0]        idx_d;
    logic                 load;
    logic [IW-1:0]        n_a;
    logic [IW-1:0]        n_b;
    logic [IW-1:0]        n_c;
    logic                 n_last;

    assign kind  = gvt_pkg::t_quad_kind'(i_job[gvt_pkg::KIND_W+4*IW-1 -: gvt_pkg::KIND_W]);
    assign idx_a = i_job[4*IW-1 -: IW];
    assign idx_b = i_job[3*IW-1 -: IW];
    assign idx_c = i_job[2*IW-1 -: IW];
    assign idx_d = i_job[IW-1:0];

    assign load = (!r_valid || i_ready) && !i_empty;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        n_a     = idx_a;
        n_b     = idx_b;
        n_c     = idx_c;
        n_last  = 1'b1;
        unique case (kind)
            gvt_pkg::QK_FULL: begin
                if (r_state == gvt_pkg::BK_FIRST) begin
                    n_last = 1'b0;
                    if (load) begin
                        n_state = gvt_pkg::BK_SECOND;
                    end
                end else begin
                    n_a = idx_b;
                    n_b = idx_d;
                    if (load) begin
                        n_state = gvt_pkg::BK_FIRST;
                        o_pop   = 1'b1;
                    end
                end
            end
            gvt_pkg::QK_NO_A: begin
                n_a   = idx_b;
                n_b   = idx_d;
                o_pop = load;
            end
            gvt_pkg::QK_NO_B: begin
                n_b   = idx_d;
                o_pop = load;
            end
            gvt_pkg::QK_NO_C: begin
                n_c   = idx_d;
                o_pop = load;
            end
            gvt_pkg::QK_NO_D: begin
                o_pop = load;
            end
            default: begin
                o_pop = load;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gvt_pkg::BK_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a    <= CW'(n_a);
            r_b    <= CW'(n_b);
            r_c    <= CW'(n_c);
            r_last <= n_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_corner_a = r_a;
    assign o_corner_b = r_b;
    assign o_corner_c = r_c;
    assign o_last     = r_last;

endmodule

// ----- rtl/grid_validity_triangulator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the grid validity triangulator: front, quad queue and back.
// Depends on gvt_pkg, gvt_front, gvt_fifo and gvt_back.
//
//  Channel   Direction  Beat carries
//  s_axis    in         tdata[0] vertex_valid; tuser[0] row bridge flag, [1] mesh_start
//  m_axis    out        tdata corner_a, corner_b, corner_c (32 bits each); tlast last of quad
//  i_cfg_wr  in         v_divisions, written when i_cfg_wr_en is high
//
// One vertex beat is taken per cycle while the queue has room.
// A quad with three valid corners gives one triangle beat, a fully valid quad two.
// An accepted vertex is registered in the front stage and its quad pushed into the
// queue, from which the back loads each triangle beat into its output register.
// The line buffer is one RAM read and written once per vertex.
// Synchronous active-low reset; the line buffer is not cleared by it.
module grid_validity_triangulator_unit #(
    parameter int MAX_COLUMNS = gvt_pkg::DEF_MAX_COLUMNS,
    parameter int INDEX_WIDTH = gvt_pkg::DEF_INDEX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [9:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] vertex_valid, [7:1] zero
    input  logic [1:0]  s_axis_tuser,   // [0] row bridge flag, [1] mesh_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [31:0] corner_a, [63:32] corner_b, [95:64] corner_c
    output logic        m_axis_tlast
);

    localparam int QW = gvt_pkg::KIND_W + 4 * INDEX_WIDTH;

    logic          push;
    logic [QW-1:0] push_data;
    logic          queue_full;
    logic          pop;
    logic [QW-1:0] job;
    logic          queue_empty;

    gvt_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_vertex_valid   (s_axis_tdata[0]),
        .i_row_bridge     (s_axis_tuser[0]),
        .i_mesh_start     (s_axis_tuser[1]),
        .o_push           (push),
        .o_push_data      (push_data),
        .i_queue_full     (queue_full)
    );

    gvt_fifo #(
        .WIDTH (QW),
        .DEPTH (gvt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_data  (job),
        .o_empty (queue_empty)
    );

    gvt_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job),
        .i_empty    (queue_empty),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_corner_a (m_axis_tdata[31:0]),
        .o_corner_b (m_axis_tdata[63:32]),
        .o_corner_c (m_axis_tdata[95:64]),
        .o_last     (m_axis_tlast)
    );

endmodule

// ----- tb/gvt_triangle_checker.sv -----
`timescale 1ns / 1ps
// Checker for the grid validity triangulator: it mirrors the line buffer and
// counters, predicts every triangle beat and compares it with the master side.
// Depends on gvt_pkg for widths and the quad classification codes.
module gvt_triangle_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [gvt_pkg::VDIV_W-1:0] i_cfg_wr_data,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [0] vertex_valid, [7:1] zero
    input  logic [1:0]                 s_axis_tuser,   // [0] row bridge flag, [1] mesh_start
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [95:0]                m_axis_tdata,   // corner_a, corner_b, corner_c
    input  logic                       m_axis_tlast,
    output int                         o_mismatches,
    output int                         o_pending
);

    localparam int COLS = gvt_pkg::DEF_MAX_COLUMNS;
    localparam int CRW  = gvt_pkg::CORNER_W;

    typedef struct packed {
        logic [CRW-1:0] a;
        logic [CRW-1:0] b;
        logic [CRW-1:0] c;
        logic           last;
    } t_triangle;

    t_triangle                    expected_tris [$];
    bit [gvt_pkg::VDIV_W-1:0]     span;
    bit                           line_buf [COLS];
    bit                           left_v;
    bit                           upleft_v;
    bit                           row_bridged;
    bit [gvt_pkg::VDIV_W-1:0]     col_cnt;
    bit [gvt_pkg::ROW_W-1:0]      row_cnt;
    bit [CRW-1:0]                 row_base;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic add_triangle(input bit [CRW-1:0] a, input bit [CRW-1:0] b,
                                input bit [CRW-1:0] c, input bit last);
        t_triangle t;
        t.a    = a;
        t.b    = b;
        t.c    = c;
        t.last = last;
        expected_tris.insert(expected_tris.size(), t);
    endtask

    task automatic take_vertex(input bit valid, input bit bridge, input bit start);
        bit [gvt_pkg::VDIV_W-1:0] eff;
        bit [CRW-1:0]             stride;
        bit [CRW-1:0]             top_row;
        bit [CRW-1:0]             ia;
        bit [CRW-1:0]             ib;
        bit [CRW-1:0]             ic;
        bit [CRW-1:0]             id;
        bit                       above;
        int                       j;
        int                       n_valid;
        gvt_pkg::t_quad_kind      kind;
        eff    = (int'(span) > COLS - 1) ? gvt_pkg::VDIV_W'(COLS - 1) : span;
        stride = CRW'(eff) + CRW'(1);
        if (start) begin
            col_cnt  = '0;
            row_cnt  = '0;
            row_base = '0;
        end
        j     = (int'(col_cnt) > COLS - 1) ? COLS - 1 : int'(col_cnt);
        above = line_buf[j];
        if (row_cnt != 0 && j != 0 && row_bridged) begin
            top_row = row_base - stride;
            ia      = top_row + CRW'(j) - CRW'(1);
            ic      = top_row + CRW'(j);
            ib      = row_base + CRW'(j) - CRW'(1);
            id      = row_base + CRW'(j);
            n_valid = int'(upleft_v) + int'(left_v) + int'(above) + int'(valid);
            if (n_valid == 4)   kind = gvt_pkg::QK_FULL;
            else if (!upleft_v) kind = gvt_pkg::QK_NO_A;
            else if (!left_v)   kind = gvt_pkg::QK_NO_B;
            else if (!above)    kind = gvt_pkg::QK_NO_C;
            else                kind = gvt_pkg::QK_NO_D;
            if (n_valid >= 3) begin
                case (kind)
                    gvt_pkg::QK_FULL: begin
                        add_triangle(ia, ib, ic, 1'b0);
                        add_triangle(ib, id, ic, 1'b1);
                    end
                    gvt_pkg::QK_NO_A: add_triangle(ib, id, ic, 1'b1);
                    gvt_pkg::QK_NO_B: add_triangle(ia, id, ic, 1'b1);
                    gvt_pkg::QK_NO_C: add_triangle(ia, ib, id, 1'b1);
                    default: add_triangle(ia, ib, ic, 1'b1);
                endcase
            end
        end
        upleft_v    = above;
        line_buf[j] = valid;
        left_v      = valid;
        if (col_cnt >= eff) begin
            col_cnt     = '0;
            row_cnt     = row_cnt + gvt_pkg::ROW_W'(1);
            row_base    = row_base + stride;
            row_bridged = bridge;
        end else begin
            col_cnt = col_cnt + gvt_pkg::VDIV_W'(1);
        end
    endtask

    task automatic check_triangle();
        t_triangle want;
        t_triangle got;
        got.a    = m_axis_tdata[31:0];
        got.b    = m_axis_tdata[63:32];
        got.c    = m_axis_tdata[95:64];
        got.last = m_axis_tlast;
        if (expected_tris.size() == 0) begin
            o_mismatches++;
            $display("%0t ns: expected no beat, got %0d %0d %0d last %0b",
                     $time, got.a, got.b, got.c, got.last);
        end else begin
            want = expected_tris.pop_front();
            if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
                    got.last !== want.last) begin
                o_mismatches++;
                $display("%0t ns: expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
                         $time, want.a, want.b, want.c, want.last,
                         got.a, got.b, got.c, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            span        = gvt_pkg::VDIV_W'(1);
            left_v      = 1'b0;
            upleft_v    = 1'b0;
            row_bridged = 1'b0;
            col_cnt     = '0;
            row_cnt     = '0;
            row_base    = '0;
            for (int k = 0; k < COLS; k++) line_buf[k] = 1'b0;
            expected_tris.delete();
        end else begin
            if (i_cfg_wr_en) span = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                take_vertex(s_axis_tdata[0], s_axis_tuser[0], s_axis_tuser[1]);
            if (m_axis_tvalid && m_axis_tready) check_triangle();
        end
        o_pending = expected_tris.size();
    end

endmodule

// ----- tb/grid_validity_triangulator_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for grid_validity_triangulator_unit: clock, reset, vertex and
// configuration stimulus, random back-pressure and the verdict.
// Depends on gvt_pkg, the block itself and gvt_triangle_checker.
module grid_validity_triangulator_unit_tb;

    localparam int RANDOM_ITEMS  = 370;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 20;
    localparam int BIG_SPAN      = 200;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_cfg_wr_en    = 1'b0;
    logic [gvt_pkg::VDIV_W-1:0] i_cfg_wr_data  = '0;
    logic                       s_axis_tvalid  = 1'b0;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata   = '0;
    logic [1:0]                 s_axis_tuser   = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready  = 1'b0;
    logic [95:0]                m_axis_tdata;
    logic                       m_axis_tlast;

    int mismatches;
    int pending;
    int cur_span    = 1;
    int col_pos     = 0;
    int hi_written  = -1;
    bit need_start  = 1'b0;
    int random_sent = 0;
    int ready_left  = 0;
    bit ready_mode  = 1'b0;

    // Each entry is {mesh_start, row bridge flag, vertex_valid}, two vertices per row.
    bit [2:0] directed_seq [23] = '{
        3'b011, 3'b011,  3'b011, 3'b011,  3'b011, 3'b010,  3'b011, 3'b011,
        3'b010, 3'b011,  3'b011, 3'b011,  3'b001, 3'b001,  3'b011, 3'b011,
        3'b010, 3'b010,  3'b111, 3'b111,  3'b011, 3'b011,  3'b011
    };

    grid_validity_triangulator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    gvt_triangle_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        int pick;
        if (ready_left == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                ready_mode = 1'b1;
                ready_left = $urandom_range(1, 8);
            end else if (pick < 65) begin
                ready_mode = 1'b1;
                ready_left = $urandom_range(40, 120);
            end else if (pick < 95) begin
                ready_mode = 1'b0;
                ready_left = $urandom_range(1, 3);
            end else begin
                ready_mode = 1'b0;
                ready_left = $urandom_range(15, 50);
            end
        end
        ready_left--;
        m_axis_tready = ready_mode;
    end

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_span();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)  return 0;
        if (pick < 14) return $urandom_range(1, 4);
        if (pick < 18) return $urandom_range(5, 12);
        return $urandom_range(13, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic push_vertex(input bit valid, input bit bridge, input bit start);
        int gap;
        gap = sender_gap();
        if (need_start) begin
            start      = 1'b1;
            need_start = 1'b0;
        end
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'b0, valid};
        s_axis_tuser  = {start, bridge};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (start) col_pos = 0;
        if (col_pos > hi_written) hi_written = col_pos;
        if (col_pos >= cur_span) col_pos = 0;
        else col_pos++;
    endtask

    task automatic push_random_vertex(input bit allow_start);
        push_vertex($urandom_range(0, 9) < 8, $urandom_range(0, 9) < 8,
                    allow_start && $urandom_range(0, 49) == 0);
    endtask

    task automatic wait_all_delivered(input int settle);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // A wider row than any written so far would read unwritten line buffer
    // entries, so such a setting starts a new mesh.
    task automatic write_span(input int value);
        wait_all_delivered(SETTLE_CYCLES);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = gvt_pkg::VDIV_W'(value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        cur_span    = value;
        if (value > hi_written) need_start = 1'b1;
    endtask

    initial begin
        int n;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_seq[k])
            push_vertex(directed_seq[k][0], directed_seq[k][1], directed_seq[k][2]);

        write_span(0);
        repeat (8) push_random_vertex(1'b1);

        write_span(BIG_SPAN);
        repeat (BIG_SPAN + 1 + 48) push_random_vertex(1'b0);

        while (random_sent < RANDOM_ITEMS) begin
            write_span(pick_span());
            n = $urandom_range(15, 60);
            repeat (n) begin
                if ($urandom_range(0, 39) == 0) wait_all_delivered(0);
                push_random_vertex(1'b1);
                random_sent++;
            end
        end

        wait_all_delivered(END_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/gvt_pkg.sv
rtl/gvt_ram.sv
rtl/gvt_fifo.sv
rtl/gvt_front.sv
rtl/gvt_back.sv
rtl/grid_validity_triangulator_unit.sv
tb/gvt_triangle_checker.sv
tb/grid_validity_triangulator_unit_tb.sv
